[hdl/krbd_pkg.sv]
// Shared types, constants and the duty scaling function for the key repeat
// backlight dimmer. No dependencies; imported by every module of the block.
package krbd_pkg;

  // Fixed field widths
  localparam int BRIGHT_W  = 7;
  localparam int TIMEOUT_W = 12;
  localparam int RPT_W     = 10;
  localparam int IDLE_W    = 22;
  localparam int DUTY_W    = 10;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 12;

  // Timing constants (ticks are 1 ms)
  localparam int DUTY_BITS           = 10;
  localparam int FADE_STEP_TICKS     = 10;
  localparam int STARTUP_DELAY_TICKS = 200;
  localparam int IDLE_MS_PER_S       = 1000;
  localparam int LEVEL_MAX           = 100;

  localparam logic [IDLE_W-1:0] IDLE_MAX = '1;
  localparam logic [7:0] FADE_RELOAD   = 8'(FADE_STEP_TICKS - 1);
  localparam logic [7:0] STARTUP_TICKS = 8'(STARTUP_DELAY_TICKS);

  // Reset values of the configuration registers
  localparam logic [BRIGHT_W-1:0] BRIGHT_RST  = 7'd100;
  localparam logic [IDLE_W-1:0]   TIMEOUT_RST = 22'd30000;
  localparam logic [RPT_W-1:0]    DELAY_RST   = 10'd300;
  localparam logic [RPT_W-1:0]    PERIOD_RST  = 10'd40;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_BRIGHTNESS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IDLE_TMO   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_RPT_DELAY  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RPT_PERIOD = 2'd3;

  // Encoder step / repeat direction codes (2-bit two's complement)
  localparam logic [1:0] DIR_NONE  = 2'b00;
  localparam logic [1:0] DIR_RIGHT = 2'b01;
  localparam logic [1:0] DIR_LEFT  = 2'b11;

  // OK key event codes
  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_PRESSED  = 2'd1;
  localparam logic [1:0] EV_RELEASED = 2'd2;

  // duty = level * (2^DUTY_BITS - 1) / 100, via a reciprocal of 100.
  // Shift chosen so the reciprocal error stays below one LSB for level <= 100.
  localparam int      DUTY_SHIFT = DUTY_BITS + 14;
  localparam longint  DUTY_MAX   = (64'd1 << DUTY_BITS) - 1;
  localparam longint  DUTY_RECIP = ((64'd1 << DUTY_SHIFT) / LEVEL_MAX) + 1;
  localparam longint  DUTY_K     = DUTY_MAX * DUTY_RECIP;
  localparam int      DUTY_K_W   = 2 * DUTY_BITS + 8;
  localparam int      DUTY_P_W   = BRIGHT_W + DUTY_K_W;

  typedef struct packed {
    logic [1:0] enc;
    logic [1:0] ev;
  } key_res_t;

  typedef struct packed {
    logic [BRIGHT_W-1:0] level;
    logic                dark;
  } light_res_t;

  typedef struct packed {
    logic [1:0]          enc;
    logic [1:0]          ev;
    logic [DUTY_W-1:0]   duty;
    logic [BRIGHT_W-1:0] level;
    logic                dark;
  } res_t;

  function automatic logic [DUTY_W-1:0] duty_of(input logic [BRIGHT_W-1:0] lvl);
    logic [DUTY_P_W-1:0] prod;
    prod = DUTY_P_W'(lvl) * DUTY_P_W'(DUTY_K);
    return DUTY_W'(prod >> DUTY_SHIFT);
  endfunction

endpackage

[hdl/krbd_keys.sv]
// Key edge detection, OK press/release events and slider auto-repeat.
// Depends on krbd_pkg; the wake flag comes from krbd_backlight.
module krbd_keys
  import krbd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             left_key,
  input  logic             right_key,
  input  logic             ok_down,
  input  logic             slider_focused,
  input  logic             wake,
  input  logic [RPT_W-1:0] rpt_delay,
  input  logic [RPT_W-1:0] rpt_period,
  output key_res_t         res
);

  logic             left_held_r, right_held_r, ok_held_r, swallow_r, repeat_on_r;
  logic [1:0]       repeat_dir_r;
  logic [RPT_W-1:0] repeat_rem_r;

  logic             left_held_nxt, right_held_nxt, ok_held_nxt, swallow_nxt, repeat_on_nxt;
  logic [1:0]       repeat_dir_nxt;
  logic [RPT_W-1:0] repeat_rem_nxt;
  logic             any_key;

  assign any_key = left_key | right_key | ok_down;

  // Key decode for one tick
  always_comb begin
    left_held_nxt  = left_held_r;
    right_held_nxt = right_held_r;
    ok_held_nxt    = ok_held_r;
    swallow_nxt    = swallow_r;
    repeat_on_nxt  = repeat_on_r;
    repeat_dir_nxt = repeat_dir_r;
    repeat_rem_nxt = repeat_rem_r;
    res.enc        = DIR_NONE;
    res.ev         = EV_NONE;

    if (swallow_r || wake) begin
      // keys eaten until everything is released
      res.ev      = EV_RELEASED;
      swallow_nxt = any_key;
      if (wake) begin
        repeat_on_nxt  = 1'b0;
        repeat_dir_nxt = DIR_NONE;
      end
    end else begin
      if (repeat_rem_nxt != '0) begin
        repeat_rem_nxt = repeat_rem_nxt - 1'b1;
      end

      if (left_key && !left_held_r) begin
        left_held_nxt  = 1'b1;
        res.enc        = DIR_LEFT;
        repeat_on_nxt  = slider_focused;
        repeat_dir_nxt = DIR_LEFT;
        repeat_rem_nxt = rpt_delay;
      end else if (!left_key && left_held_r) begin
        left_held_nxt = 1'b0;
        if (repeat_dir_nxt == DIR_LEFT) begin
          repeat_on_nxt  = 1'b0;
          repeat_dir_nxt = DIR_NONE;
        end
      end

      if (right_key && !right_held_r) begin
        right_held_nxt = 1'b1;
        res.enc        = DIR_RIGHT;
        repeat_on_nxt  = slider_focused;
        repeat_dir_nxt = DIR_RIGHT;
        repeat_rem_nxt = rpt_delay;
      end else if (!right_key && right_held_r) begin
        right_held_nxt = 1'b0;
        if (repeat_dir_nxt == DIR_RIGHT) begin
          repeat_on_nxt  = 1'b0;
          repeat_dir_nxt = DIR_NONE;
        end
      end

      // auto-repeat while the key stays down
      if (res.enc == DIR_NONE && repeat_on_nxt && repeat_dir_nxt != DIR_NONE &&
          ((repeat_dir_nxt == DIR_LEFT && left_key) ||
           (repeat_dir_nxt == DIR_RIGHT && right_key)) &&
          repeat_rem_nxt == '0) begin
        res.enc        = repeat_dir_nxt;
        repeat_rem_nxt = rpt_period;
      end

      if (ok_down && !ok_held_r) begin
        ok_held_nxt = 1'b1;
        res.ev      = EV_PRESSED;
      end else if (!ok_down && ok_held_r) begin
        ok_held_nxt = 1'b0;
        res.ev      = EV_RELEASED;
      end
    end
  end

  // State update on each accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_held_r  <= 1'b0;
      right_held_r <= 1'b0;
      ok_held_r    <= 1'b0;
      swallow_r    <= 1'b0;
      repeat_on_r  <= 1'b0;
      repeat_dir_r <= DIR_NONE;
      repeat_rem_r <= '0;
    end else if (step) begin
      left_held_r  <= left_held_nxt;
      right_held_r <= right_held_nxt;
      ok_held_r    <= ok_held_nxt;
      swallow_r    <= swallow_nxt;
      repeat_on_r  <= repeat_on_nxt;
      repeat_dir_r <= repeat_dir_nxt;
      repeat_rem_r <= repeat_rem_nxt;
    end
  end

  // Repeat is always cleared on wake and never armed while swallowing
  a_swallow_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    swallow_r |-> !repeat_on_r)
    else $error("repeat armed while keys are swallowed");

  // An armed repeat always has a direction
  a_repeat_has_dir: assert property (@(posedge clk) disable iff (!rst_n)
    repeat_on_r |-> (repeat_dir_r == DIR_LEFT || repeat_dir_r == DIR_RIGHT))
    else $error("repeat armed without direction");

endmodule

[hdl/krbd_backlight.sv]
// Backlight sequencer: startup wait, fades, idle timeout, dark and wake.
// Depends on krbd_pkg; drives the wake flag used by krbd_keys.
module krbd_backlight
  import krbd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                any_key,
  input  logic [BRIGHT_W-1:0] bright_target,
  input  logic [IDLE_W-1:0]   idle_limit,
  output logic                wake,
  output light_res_t          res
);

  typedef enum logic [2:0] {
    M_WAIT,
    M_SFADE,
    M_ON,
    M_FDOWN,
    M_DARK,
    M_FUP
  } mode_t;

  mode_t               mode_r, mode_nxt;
  logic [IDLE_W-1:0]   idle_ms_r, idle_ms_nxt;
  logic [BRIGHT_W-1:0] level_r, level_nxt;
  logic [7:0]          fade_tmr_r, fade_tmr_nxt;
  logic [BRIGHT_W-1:0] goal;
  logic [BRIGHT_W-1:0] fade_goal;
  logic                counting;

  assign goal     = (bright_target > BRIGHT_W'(LEVEL_MAX)) ? BRIGHT_W'(LEVEL_MAX)
                                                           : bright_target;
  assign wake     = any_key && (mode_r == M_DARK);
  assign counting = (mode_r != M_WAIT) && (mode_r != M_SFADE);

  // One tick of the backlight sequence
  always_comb begin
    mode_nxt     = mode_r;
    idle_ms_nxt  = idle_ms_r;
    level_nxt    = level_r;
    fade_tmr_nxt = fade_tmr_r;
    fade_goal    = goal;

    // activity and idle count
    if (any_key) begin
      if (counting) begin
        idle_ms_nxt = '0;
      end
      if (mode_r == M_DARK || mode_r == M_FDOWN) begin
        mode_nxt     = M_FUP;
        fade_tmr_nxt = '0;
      end
    end else if (counting && idle_ms_r != IDLE_MAX) begin
      idle_ms_nxt = idle_ms_r + 1'b1;
    end

    // startup wait and timeout check
    if (mode_nxt == M_WAIT) begin
      if (fade_tmr_nxt >= STARTUP_TICKS) begin
        mode_nxt     = M_SFADE;
        fade_tmr_nxt = '0;
      end else begin
        fade_tmr_nxt = fade_tmr_nxt + 1'b1;
      end
    end else if (mode_nxt == M_ON) begin
      level_nxt = goal;
      if (idle_limit != '0 && idle_ms_nxt >= idle_limit) begin
        mode_nxt     = M_FDOWN;
        fade_tmr_nxt = '0;
      end
    end

    // fade engine: one percent per step, then a hold before finishing
    if (mode_nxt == M_SFADE || mode_nxt == M_FUP || mode_nxt == M_FDOWN) begin
      if (mode_nxt == M_FDOWN) begin
        fade_goal = '0;
      end
      if (fade_tmr_nxt != '0) begin
        fade_tmr_nxt = fade_tmr_nxt - 1'b1;
      end else if (level_nxt == fade_goal) begin
        if (mode_nxt == M_FDOWN) begin
          mode_nxt = M_DARK;
        end else begin
          if (mode_nxt == M_SFADE) begin
            idle_ms_nxt = '0;
          end
          mode_nxt = M_ON;
        end
      end else begin
        if (level_nxt < fade_goal) begin
          level_nxt = level_nxt + 1'b1;
        end else begin
          level_nxt = level_nxt - 1'b1;
        end
        fade_tmr_nxt = FADE_RELOAD;
      end
    end

    res.level = level_nxt;
    res.dark  = (mode_nxt == M_DARK);
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_WAIT;
      idle_ms_r  <= '0;
      level_r    <= '0;
      fade_tmr_r <= '0;
    end else if (step) begin
      mode_r     <= mode_nxt;
      idle_ms_r  <= idle_ms_nxt;
      level_r    <= level_nxt;
      fade_tmr_r <= fade_tmr_nxt;
    end
  end

  // Dark only ever follows a completed fade to zero
  a_dark_is_off: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == M_DARK) |-> (level_r == '0))
    else $error("dark with nonzero level");

  // Idle counter is held while starting up
  a_idle_startup: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == M_WAIT) |-> (idle_ms_r == '0))
    else $error("idle counter moved during startup wait");

endmodule

[hdl/key_repeat_backlight_dimmer.sv]
// Top level of the key repeat backlight dimmer: config registers, output
// skid buffer and duty scaling. Depends on krbd_pkg, krbd_keys, krbd_backlight.
//
// Usage:
//  - Input channel (in_valid/in_stall): one transaction per 1 ms tick with
//    the left, right and OK key levels and the slider-focus flag.
//  - Result channel (out_valid/out_stall): exactly one result per input
//    transaction: encoder step, OK event, PWM duty, level and dark flag.
//  - Config channel (cfg_valid/cfg_ready): cfg_addr selects brightness
//    target, idle timeout in seconds, repeat delay, repeat period. Write
//    only while no transaction is in flight. cfg_ready is always high.
//  - Throughput: one tick per clock while in_stall is low; all work for a
//    tick is one pass of combinational logic into the result register, or
//    into the skid register while a result waits.
//  - A two-entry output buffer (result register plus skid register) lets a
//    tick be accepted while a result waits; in_stall rises only when both
//    are full, i.e. once a tick is accepted while the receiver stalls a
//    waiting result, and drops the cycle after the receiver takes one.
//  - Reset (rst_n low, synchronous) empties the buffer, restores the config
//    defaults and starts the startup wait, after which the backlight fades up.
module key_repeat_backlight_dimmer
  import krbd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input ticks
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_left_key,
  input  logic                  in_right_key,
  input  logic                  in_ok_down,
  input  logic                  in_slider_focused,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [1:0]     out_enc_step,
  output logic [1:0]            out_press_event,
  output logic [DUTY_W-1:0]     out_pwm_duty,
  output logic [BRIGHT_W-1:0]   out_level_now,
  output logic                  out_screen_dark,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [BRIGHT_W-1:0] bright_r;
  logic [IDLE_W-1:0]   idle_limit_r;
  logic [RPT_W-1:0]    rpt_delay_r, rpt_period_r;

  logic       step, take, any_key, wake;
  key_res_t   key_res;
  light_res_t light_res;
  res_t       res_new;
  res_t       main_r, skid_r;
  logic       main_valid_r, skid_valid_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign step      = in_valid && !skid_valid_r;
  assign take      = main_valid_r && !out_stall;
  assign any_key   = in_left_key | in_right_key | in_ok_down;

  // Configuration registers; the timeout is kept in ms
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r     <= BRIGHT_RST;
      idle_limit_r <= TIMEOUT_RST;
      rpt_delay_r  <= DELAY_RST;
      rpt_period_r <= PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        REG_BRIGHTNESS: bright_r     <= cfg_wdata[BRIGHT_W-1:0];
        REG_IDLE_TMO:   idle_limit_r <= IDLE_W'(cfg_wdata) * IDLE_W'(IDLE_MS_PER_S);
        REG_RPT_DELAY:  rpt_delay_r  <= cfg_wdata[RPT_W-1:0];
        REG_RPT_PERIOD: rpt_period_r <= cfg_wdata[RPT_W-1:0];
        default: ;
      endcase
    end
  end

  krbd_keys u_keys (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .left_key       (in_left_key),
    .right_key      (in_right_key),
    .ok_down        (in_ok_down),
    .slider_focused (in_slider_focused),
    .wake           (wake),
    .rpt_delay      (rpt_delay_r),
    .rpt_period     (rpt_period_r),
    .res            (key_res)
  );

  krbd_backlight u_light (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .any_key       (any_key),
    .bright_target (bright_r),
    .idle_limit    (idle_limit_r),
    .wake          (wake),
    .res           (light_res)
  );

  // Assemble the result of this tick
  always_comb begin
    res_new.enc   = key_res.enc;
    res_new.ev    = key_res.ev;
    res_new.duty  = duty_of(light_res.level);
    res_new.level = light_res.level;
    res_new.dark  = light_res.dark;
  end

  // Output buffer: result register plus skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!main_valid_r || take) begin
        main_valid_r <= skid_valid_r || step;
        skid_valid_r <= 1'b0;
      end else if (step) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid_r || take) begin
      main_r <= skid_valid_r ? skid_r : res_new;
    end
    if (!skid_valid_r) begin
      skid_r <= res_new;
    end
  end

  assign out_valid       = main_valid_r;
  assign out_enc_step    = signed'(main_r.enc);
  assign out_press_event = main_r.ev;
  assign out_pwm_duty    = main_r.duty;
  assign out_level_now   = main_r.level;
  assign out_screen_dark = main_r.dark;

  // Skid entry is only ever occupied behind a waiting result
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry valid with empty result register");

endmodule
